### rtl/rbs_pkg.sv
// Shared types and constants for the ray / box slab test.
// No dependencies.
package rbs_pkg;

    localparam int OUT_W = 31;
    localparam int NUM_AXES = 3;
    localparam int NUM_REGS = 6;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } reg_idx_t;

    // per-axis status leaving a lane
    typedef struct packed {
        logic par;    // direction component is zero
        logic pmiss;  // parallel and origin outside the slab
    } lane_flags_t;

endpackage

### rtl/rbs_ifs.sv
// Valid/ready stream interfaces for ray items and test results.
// Depends on rbs_pkg.
interface rbs_ray_if #(parameter int CW = 32);
    logic          valid;
    logic          ready;
    logic [CW-1:0] origin_x;
    logic [CW-1:0] origin_y;
    logic [CW-1:0] origin_z;
    logic [CW-1:0] dir_x;
    logic [CW-1:0] dir_y;
    logic [CW-1:0] dir_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rbs_hit_if;
    import rbs_pkg::*;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [OUT_W-1:0] t_enter;
    logic [OUT_W-1:0] t_exit;
    modport source (output valid, hit, t_enter, t_exit, input ready);
    modport sink (input valid, hit, t_enter, t_exit, output ready);
endinterface

### rtl/ray_box_slab_intersection_top.sv
// Ray / box slab test. From input transfer to result a ray passes one prep stage,
// COORD_WIDTH-1 divider stages and one result register.
// Throughput one ray per cycle; the pipeline advances whenever the result
// register is empty or being taken. rst_n clears valid flags and box registers.
// Depends on rbs_pkg, rbs_ifs, rbs_lane, rbs_merge.
module ray_box_slab_intersection_top
    import rbs_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    rbs_ray_if.sink              ray,
    rbs_hit_if.source            res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [(COORD_WIDTH > 32 ? 6 : 5)-1:0] paddr,
    input  logic [(COORD_WIDTH > 32 ? 64 : 32)-1:0] pwdata,
    output logic [(COORD_WIDTH > 32 ? 64 : 32)-1:0] prdata,
    output logic                 pready
);
    localparam int CW  = COORD_WIDTH;
    localparam int DW  = (CW > 32) ? 64 : 32;
    localparam int AW  = (CW > 32) ? 6 : 5;
    localparam int SH  = (CW > 32) ? 3 : 2;
    localparam int LAT = CW;

    logic signed [CW-1:0] box_reg [NUM_REGS];
    logic [LAT-1:0]       vld_reg;
    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [OUT_W-1:0]     t_enter_reg;
    logic [OUT_W-1:0]     t_exit_reg;
    logic                 en;
    logic [2:0]           widx;

    logic signed [CW-1:0] org [NUM_AXES];
    logic signed [CW-1:0] dir [NUM_AXES];
    logic signed [CW-1:0] ta  [NUM_AXES];
    logic signed [CW-1:0] tb  [NUM_AXES];
    lane_flags_t          flg [NUM_AXES];
    logic                 hit_next;
    logic [OUT_W-1:0]     t_enter_next;
    logic [OUT_W-1:0]     t_exit_next;

    assign pready = 1'b1;
    assign widx   = 3'(paddr[AW-1:SH]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                box_reg[i] <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                if (widx == 3'(i))
                    box_reg[i] <= pwdata[CW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < NUM_REGS; i++)
            if (widx == 3'(i))
                prdata = DW'(box_reg[i]);
    end

    assign en        = !out_valid_reg || res.ready;
    assign ray.ready = en;

    assign org[0] = ray.origin_x;
    assign org[1] = ray.origin_y;
    assign org[2] = ray.origin_z;
    assign dir[0] = ray.dir_x;
    assign dir[1] = ray.dir_y;
    assign dir[2] = ray.dir_z;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        rbs_lane #(.CW(CW), .FB(FRAC_BITS)) u_lane (
            .clk   (clk),
            .en    (en),
            .org   (org[a]),
            .dir   (dir[a]),
            .lo    (box_reg[a]),
            .hi    (box_reg[a + NUM_AXES]),
            .ta    (ta[a]),
            .tb    (tb[a]),
            .flags (flg[a])
        );
    end

    rbs_merge #(.CW(CW)) u_merge (
        .ta      (ta),
        .tb      (tb),
        .flags   (flg),
        .hit     (hit_next),
        .t_enter (t_enter_next),
        .t_exit  (t_exit_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], ray.valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg     <= hit_next;
            t_enter_reg <= t_enter_next;
            t_exit_reg  <= t_exit_next;
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.hit     = hit_reg;
    assign res.t_enter = t_enter_reg;
    assign res.t_exit  = t_exit_reg;

endmodule

### rtl/rbs_lane.sv
// One axis lane: slab plane offsets and two pipelined restoring dividers,
// one quotient bit per stage. Depends on rbs_pkg.
module rbs_lane
    import rbs_pkg::*;
#(
    parameter int CW = 32,
    parameter int FB = 16
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] org,
    input  logic signed [CW-1:0] dir,
    input  logic signed [CW-1:0] lo,
    input  logic signed [CW-1:0] hi,
    output logic signed [CW-1:0] ta,
    output logic signed [CW-1:0] tb,
    output lane_flags_t          flags
);
    localparam int NW = CW + 1;
    localparam int WW = 2 * CW + FB;
    localparam int QW = CW - 1;
    localparam int NS = CW;   // prep register plus QW divide steps

    logic [WW-1:0]  rem_reg  [2][NS];
    logic [QW-1:0]  quo_reg  [2][NS];
    logic           neg_reg  [2][NS];
    logic           sat_reg  [2][NS];
    logic [CW-1:0]  den_reg  [NS];
    lane_flags_t    flg_reg  [NS];

    logic signed [NW-1:0] diff [2];
    logic [NW-1:0]        nmag [2];
    logic [CW-1:0]        dmag;
    logic signed [CW-1:0] bnd  [2];
    logic signed [CW-1:0] tres [2];

    assign bnd[0] = lo;
    assign bnd[1] = hi;
    assign dmag   = dir[CW-1] ? CW'(-dir) : dir;

    always_comb
    begin
        for (int p = 0; p < 2; p++)
        begin
            diff[p] = NW'(bnd[p]) - NW'(org);
            nmag[p] = diff[p][NW-1] ? NW'(-diff[p]) : NW'(diff[p]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]       <= dmag;
            flg_reg[0].par   <= (dir == '0);
            flg_reg[0].pmiss <= (dir == '0) && ((org < lo) || (org > hi));
            for (int p = 0; p < 2; p++)
            begin
                rem_reg[p][0] <= WW'(nmag[p]) << FB;
                quo_reg[p][0] <= '0;
                neg_reg[p][0] <= diff[p][NW-1] ^ dir[CW-1];
                sat_reg[p][0] <= ((WW'(nmag[p]) << FB) >= (WW'(dmag) << (CW - 1)));
            end
            // stage k resolves quotient bit QW-1-k
            for (int k = 0; k < QW; k++)
            begin
                den_reg[k+1] <= den_reg[k];
                flg_reg[k+1] <= flg_reg[k];
                for (int p = 0; p < 2; p++)
                begin
                    neg_reg[p][k+1] <= neg_reg[p][k];
                    sat_reg[p][k+1] <= sat_reg[p][k];
                    if (rem_reg[p][k] >= (WW'(den_reg[k]) << (QW - 1 - k)))
                    begin
                        rem_reg[p][k+1] <= rem_reg[p][k] - (WW'(den_reg[k]) << (QW - 1 - k));
                        quo_reg[p][k+1] <= quo_reg[p][k] | (QW'(1) << (QW - 1 - k));
                    end
                    else
                    begin
                        rem_reg[p][k+1] <= rem_reg[p][k];
                        quo_reg[p][k+1] <= quo_reg[p][k];
                    end
                end
            end
        end
    end

    // apply sign and saturation
    always_comb
    begin
        for (int p = 0; p < 2; p++)
        begin
            if (sat_reg[p][NS-1])
                tres[p] = neg_reg[p][NS-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            else if (neg_reg[p][NS-1])
                tres[p] = -$signed({1'b0, quo_reg[p][NS-1]});
            else
                tres[p] = $signed({1'b0, quo_reg[p][NS-1]});
        end
    end

    assign ta    = tres[0];
    assign tb    = tres[1];
    assign flags = flg_reg[NS-1];

endmodule

### rtl/rbs_merge.sv
// Merges the three lanes: orders plane distances, folds entry max / exit min,
// decides hit and clamps the outputs. Depends on rbs_pkg.
module rbs_merge
    import rbs_pkg::*;
#(
    parameter int CW = 32
)
(
    input  logic signed [CW-1:0] ta [NUM_AXES],
    input  logic signed [CW-1:0] tb [NUM_AXES],
    input  lane_flags_t          flags [NUM_AXES],
    output logic                 hit,
    output logic [OUT_W-1:0]     t_enter,
    output logic [OUT_W-1:0]     t_exit
);
    localparam logic signed [63:0] OUT_MAX = 64'sh7FFF_FFFF;

    logic signed [CW-1:0] tmin;
    logic signed [CW-1:0] tmax;
    logic signed [CW-1:0] near;
    logic signed [CW-1:0] far;
    logic                 pmiss;
    logic signed [63:0]   te;
    logic signed [63:0]   tx;

    always_comb
    begin
        tmin  = {1'b1, {(CW-1){1'b0}}};
        tmax  = {1'b0, {(CW-1){1'b1}}};
        pmiss = 1'b0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            near = (ta[a] > tb[a]) ? tb[a] : ta[a];
            far  = (ta[a] > tb[a]) ? ta[a] : tb[a];
            pmiss = pmiss | flags[a].pmiss;
            if (!flags[a].par)
            begin
                if (near > tmin)
                    tmin = near;
                if (far < tmax)
                    tmax = far;
            end
        end
        hit = !pmiss && (tmin <= tmax) && (tmax > 0);
        te  = (tmin > 0) ? 64'(tmin) : 64'sd0;
        tx  = 64'(tmax);
        if (te > OUT_MAX)
            te = OUT_MAX;
        if (tx > OUT_MAX)
            tx = OUT_MAX;
        t_enter = hit ? te[OUT_W-1:0] : '0;
        t_exit  = hit ? tx[OUT_W-1:0] : '0;
    end

endmodule

### rtl/rbs_checker.sv
// Port-level checks for the slab test top level, attached by bind.
// Depends on rbs_pkg and ray_box_slab_intersection_top.
module rbs_port_props
    import rbs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic             hit,
    input logic [OUT_W-1:0] t_enter,
    input logic [OUT_W-1:0] t_exit
);
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (t_enter == '0 && t_exit == '0))
        else $error("miss result carries nonzero distance");

    a_enter_le_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (t_enter <= t_exit))
        else $error("entry distance beyond exit distance");

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track output stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(hit) && $stable(t_enter)
                                       && $stable(t_exit)))
        else $error("stalled result changed");

endmodule

bind ray_box_slab_intersection_top rbs_port_props u_rbs_port_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (ray.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .hit       (res.hit),
    .t_enter   (res.t_enter),
    .t_exit    (res.t_exit)
);
